### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/mi3_pkg.sv
package mi3_pkg;

   localparam int ELEM_W  = 24;
   localparam int OUT_W   = 32;
   localparam int COF_W   = 49;
   localparam int MAG_W   = 48;
   localparam int DET_W   = 74;
   localparam int DMAG_W  = 74;
   localparam int QB      = 33;
   localparam int REM_W   = DMAG_W + 1 + QB;
   localparam int DIV_LAT = QB + 1;
   localparam int NELEM   = 9;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [QB-1:0]    LIM_POS = 33'h0_7FFF_FFFF;
   localparam logic [QB-1:0]    LIM_NEG = 33'h0_8000_0000;

   localparam logic RES_INVERSE  = 1'b0;
   localparam logic RES_ADJUGATE = 1'b1;

   typedef struct packed {
      logic                             mode;
      logic                             singular;
      logic                             dneg;
      logic [OUT_W-1:0]                 det;
      logic [DMAG_W-1:0]                dmag;
      logic [NELEM-1:0]                 aneg;
      logic [NELEM-1:0][MAG_W-1:0]      am;
   } qent_type;

   // sign and magnitude to a saturated 32-bit two's complement word
   function automatic logic [OUT_W-1:0] sat32(input logic neg, input logic ovf,
                                              input logic [QB-1:0] mag);
      logic [OUT_W-1:0] r;
      if (!neg) begin
         r = (ovf || mag > LIM_POS) ? SAT_POS : mag[OUT_W-1:0];
      end else begin
         r = (ovf || mag > LIM_NEG) ? SAT_NEG : OUT_W'(0) - mag[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/mi3_front.sv
module mi3_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   mode,
   input  logic                                   req_valid,
   input  logic signed [mi3_pkg::ELEM_W-1:0]      m [mi3_pkg::NELEM],
   output logic                                   push,
   output mi3_pkg::qent_type                      push_data
);
   import mi3_pkg::*;

   // product operand indices: cofactor k = m[PA]*m[PB] - m[NA]*m[NB]
   localparam logic [3:0] PA [NELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] PB [NELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] NA [NELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] NB [NELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   logic [5:0] v_ff;
   logic [5:0] mode_ff;

   logic signed [2*ELEM_W-1:0] pp_ff [NELEM];
   logic signed [2*ELEM_W-1:0] pn_ff [NELEM];
   logic signed [ELEM_W-1:0]   m1_ff [3];
   logic signed [ELEM_W-1:0]   m2_ff [3];
   logic signed [COF_W-1:0]    a2_ff [NELEM];

   logic signed [COF_W-1:0]    pl3_ff [3];
   logic signed [COF_W-1:0]    ph3_ff [3];
   logic [NELEM-1:0][MAG_W-1:0] am3_ff, am4_ff, am5_ff, am6_ff;
   logic [NELEM-1:0]            an3_ff, an4_ff, an5_ff, an6_ff;
   logic signed [DET_W-1:0]    t4_ff [3];
   logic signed [DET_W-1:0]    d5_ff;
   logic                       dneg6_ff;
   logic [DMAG_W-1:0]          dmag6_ff;

   logic [DMAG_W:0] rnd_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (enable) begin
         v_ff <= {v_ff[4:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mode_ff <= {mode_ff[4:0], mode};
         for (int k = 0; k < NELEM; k++) begin
            pp_ff[k] <= m[PA[k]] * m[PB[k]];
            pn_ff[k] <= m[NA[k]] * m[NB[k]];
            a2_ff[k] <= COF_W'(pp_ff[k]) - COF_W'(pn_ff[k]);
            an3_ff[k] <= a2_ff[k][COF_W-1];
            am3_ff[k] <= a2_ff[k][COF_W-1] ? MAG_W'(-a2_ff[k]) : MAG_W'(a2_ff[k]);
         end
         for (int r = 0; r < 3; r++) begin
            m1_ff[r]  <= m[r];
            m2_ff[r]  <= m1_ff[r];
            // split the cofactor into a signed high and unsigned low half
            pl3_ff[r] <= m2_ff[r] * $signed({1'b0, a2_ff[3*r][23:0]});
            ph3_ff[r] <= m2_ff[r] * $signed(a2_ff[3*r][COF_W-1:24]);
            t4_ff[r]  <= (DET_W'(ph3_ff[r]) <<< 24) + DET_W'(pl3_ff[r]);
         end
         d5_ff    <= t4_ff[0] + t4_ff[1] + t4_ff[2];
         dneg6_ff <= d5_ff[DET_W-1];
         dmag6_ff <= d5_ff[DET_W-1] ? DMAG_W'(-d5_ff) : DMAG_W'(d5_ff);
         am4_ff <= am3_ff;  an4_ff <= an3_ff;
         am5_ff <= am4_ff;  an5_ff <= an4_ff;
         am6_ff <= am5_ff;  an6_ff <= an5_ff;
      end
   end

   // Q26.48 to Q16.16, half away from zero
   assign rnd_w = {1'b0, dmag6_ff} + (DMAG_W+1)'(64'h8000_0000);

   always_comb begin
      push_data.mode     = mode_ff[5];
      push_data.singular = (mode_ff[5] == RES_INVERSE) && (dmag6_ff == '0);
      push_data.dneg     = dneg6_ff;
      push_data.det      = sat32(dneg6_ff, |rnd_w[DMAG_W:32+QB], rnd_w[32+QB-1:32]);
      push_data.dmag     = dmag6_ff;
      push_data.aneg     = an6_ff;
      push_data.am       = am6_ff;
   end

   assign push = enable && v_ff[5];

endmodule

### hw/rtl/mi3_queue.sv
module mi3_queue #(
   parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mi3_pkg::qent_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output mi3_pkg::qent_type head
);
   import mi3_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qent_type        ent_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= bump(wr_ff);
         if (pop)  rd_ff <= bump(rd_ff);
         if (push && !pop)      cnt_ff <= cnt_ff + CW'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_data;
   end

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = ent_ff[rd_ff];

endmodule

### hw/rtl/mi3_div.sv
module mi3_div (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [mi3_pkg::MAG_W-1:0]     am,
   input  logic [mi3_pkg::DMAG_W-1:0]    dmag,
   output logic [mi3_pkg::QB-1:0]        q,
   output logic                          ovf
);
   import mi3_pkg::*;

   // round(am * 2^32 / dmag) = floor((am * 2^33 + dmag) / (2 * dmag))
   logic [REM_W-1:0]  rem_ff [QB+1];
   logic [QB-1:0]     q_ff   [QB+1];
   logic [DMAG_W:0]   dv_ff  [QB+1];
   logic              ovf_ff [QB+1];

   logic [REM_W-1:0]  num_w;
   logic [DMAG_W:0]   dv_w;

   assign num_w = (REM_W'(am) << QB) + REM_W'(dmag);
   assign dv_w  = {dmag, 1'b0};

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_w;
         q_ff[0]   <= '0;
         dv_ff[0]  <= dv_w;
         ovf_ff[0] <= num_w >= (REM_W'(dv_w) << QB);
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int SH = QB - 1 - k;
      logic [REM_W-1:0] sub_w;
      logic             ge_w;
      assign sub_w = REM_W'(dv_ff[k]) << SH;
      assign ge_w  = rem_ff[k] >= sub_w;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge_w ? rem_ff[k] - sub_w : rem_ff[k];
            q_ff[k+1]   <= {q_ff[k][QB-2:0], ge_w};
            dv_ff[k+1]  <= dv_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign q   = q_ff[QB];
   assign ovf = ovf_ff[QB];

endmodule

### hw/rtl/mi3_back.sv
module mi3_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  mi3_pkg::qent_type             head,
   output logic                          pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [mi3_pkg::OUT_W-1:0]     res [mi3_pkg::NELEM],
   output logic [mi3_pkg::OUT_W-1:0]     det,
   output logic                          singular
);
   import mi3_pkg::*;

   typedef struct packed {
      logic                         mode;
      logic                         singular;
      logic                         dneg;
      logic [OUT_W-1:0]             det;
      logic [NELEM-1:0]             aneg;
      logic [NELEM-1:0][OUT_W-1:0]  adj;
   } side_type;

   logic              en;
   logic              v0_ff;
   qent_type          e0_ff;
   logic [DIV_LAT-1:0] vl_ff;
   side_type          side_ff [DIV_LAT];
   side_type          side_in;
   logic [QB-1:0]     q_w   [NELEM];
   logic              ovf_w [NELEM];
   logic [MAG_W:0]    adj_sum;

   logic              rsp_valid_ff, sing_ff;
   logic [OUT_W-1:0]  res_ff [NELEM];
   logic [OUT_W-1:0]  det_ff;

   // whole back end moves as one when the output register is free
   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && head_valid;

   always_comb begin
      side_in.mode     = e0_ff.mode;
      side_in.singular = e0_ff.singular;
      side_in.dneg     = e0_ff.dneg;
      side_in.det      = e0_ff.det;
      side_in.aneg     = e0_ff.aneg;
      adj_sum          = '0;
      for (int e = 0; e < NELEM; e++) begin
         adj_sum        = {1'b0, e0_ff.am[e]} + (MAG_W+1)'(16'h8000);
         side_in.adj[e] = sat32(e0_ff.aneg[e], 1'b0, adj_sum[MAG_W:16]);
      end
   end

   for (genvar e = 0; e < NELEM; e++) begin : g_lane
      mi3_div u_div (
         .clock  (clock),
         .enable (en),
         .am     (e0_ff.am[e]),
         .dmag   (e0_ff.dmag),
         .q      (q_w[e]),
         .ovf    (ovf_w[e])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         vl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff        <= head_valid;
         vl_ff        <= {vl_ff[DIV_LAT-2:0], v0_ff};
         rsp_valid_ff <= vl_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff      <= head;
         side_ff[0] <= side_in;
         for (int s = 1; s < DIV_LAT; s++) side_ff[s] <= side_ff[s-1];
         for (int e = 0; e < NELEM; e++) begin
            if (side_ff[DIV_LAT-1].mode == RES_ADJUGATE) begin
               res_ff[e] <= side_ff[DIV_LAT-1].adj[e];
            end else if (side_ff[DIV_LAT-1].singular) begin
               res_ff[e] <= '0;
            end else begin
               res_ff[e] <= sat32(side_ff[DIV_LAT-1].aneg[e] ^ side_ff[DIV_LAT-1].dneg,
                                  ovf_w[e], q_w[e]);
            end
         end
         det_ff  <= side_ff[DIV_LAT-1].det;
         sing_ff <= side_ff[DIV_LAT-1].singular;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign res       = res_ff;
   assign det       = det_ff;
   assign singular  = sing_ff;

endmodule

### hw/rtl/matrix_inverse_3x3.sv
// 3x3 inverse / adjugate engine. One matrix of nine signed Q8.16 elements
// is taken per cycle unless req_stall is high, and one result (nine Q16.16
// elements, determinant, singular flag) comes out per item, in order. Fully
// pipelined: a six-stage front forms cofactors and the exact determinant, a
// small queue follows, and the back end runs nine 33-stage restoring
// dividers side by side, one quotient bit per stage, so throughput is one
// item per cycle when nothing stalls. csr_write_data selects inverse (0) or
// unscaled adjugate (1); change it only while no item is in flight.
module matrix_inverse_3x3 #(
   parameter int Q_DEPTH = mi3_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m00,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m01,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m02,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m10,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m11,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m12,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m20,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m21,
   input  logic signed [mi3_pkg::ELEM_W-1:0]  req_m22,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r00,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r01,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r02,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r10,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r11,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r12,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r20,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r21,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_r22,
   output logic signed [mi3_pkg::OUT_W-1:0]   rsp_determinant,
   output logic                               rsp_singular
);
   import mi3_pkg::*;

   logic                     mode_ff;
   logic signed [ELEM_W-1:0] m_w [NELEM];
   logic                     q_full, q_nempty, push, pop;
   qent_type                 push_data, head;
   logic [OUT_W-1:0]         res_w [NELEM];
   logic [OUT_W-1:0]         det_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= RES_INVERSE;
      end else if (csr_write_enable) begin
         mode_ff <= csr_write_data;
      end
   end

   assign m_w = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                  req_m20, req_m21, req_m22};

   assign req_stall = q_full;

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (!q_full),
      .mode      (mode_ff),
      .req_valid (req_valid),
      .m         (m_w),
      .push      (push),
      .push_data (push_data)
   );

   mi3_queue #(.DEPTH(Q_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_nempty),
      .head      (head)
   );

   mi3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_nempty),
      .head       (head),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .res        (res_w),
      .det        (det_w),
      .singular   (rsp_singular)
   );

   assign rsp_r00 = res_w[0];
   assign rsp_r01 = res_w[1];
   assign rsp_r02 = res_w[2];
   assign rsp_r10 = res_w[3];
   assign rsp_r11 = res_w[4];
   assign rsp_r12 = res_w[5];
   assign rsp_r20 = res_w[6];
   assign rsp_r21 = res_w[7];
   assign rsp_r22 = res_w[8];
   assign rsp_determinant = det_w;

endmodule

### hw/rtl/mi3_checker.sv
`include "assert_macros.svh"

module mi3_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r00,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r01,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r02,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r10,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r11,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r12,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r20,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r21,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_r22,
   input logic signed [mi3_pkg::OUT_W-1:0]  rsp_determinant,
   input logic                              rsp_singular
);

   // a singular item carries all-zero elements
   `ASSERT_IMPL(a_sing_zero, clock, reset, rsp_valid && rsp_singular,
      rsp_r00 == 0 && rsp_r01 == 0 && rsp_r02 == 0 && rsp_r10 == 0 && rsp_r11 == 0 &&
      rsp_r12 == 0 && rsp_r20 == 0 && rsp_r21 == 0 && rsp_r22 == 0)

   // singular only on an exactly zero determinant
   `ASSERT_IMPL(a_sing_det, clock, reset, rsp_valid && rsp_singular, rsp_determinant == 0)

   // queue comes out of reset not full, so req_stall is low
   `ASSERT_NEXT(a_rst_ready, clock, 1'b0, reset, !req_stall)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_r00) && $stable(rsp_determinant) && $stable(rsp_singular))

endmodule

bind matrix_inverse_3x3 mi3_checker u_chk (.*);
